FILE: hdl/um_alu_pkg.sv
// Package for the UM32 register ALU execute block.
// Request/result structs, opcode and fault codes. No dependencies.
package um_alu_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    OP_CMOV = 3'd0,
    OP_ADD  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NAND = 3'd4,
    OP_IMM  = 3'd5,
    OP_IN   = 3'd6,
    OP_OUT  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_DIV_ZERO  = 2'd1,
    FAULT_OUT_RANGE = 2'd2
  } fault_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  reg_a;
    logic [2:0]  reg_b;
    logic [2:0]  reg_c;
    logic [31:0] immediate;
    logic [7:0]  in_byte;
    logic        in_end;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_byte_valid;
    logic [31:0] written_value;
    logic [1:0]  fault;
  } res_t;

  // serial unit control
  typedef struct packed {
    logic       start;
    logic [1:0] sel;   // 0 add, 1 mul, 2 div
  } ser_ctl_t;

  localparam logic [1:0] SerAdd = 2'd0;
  localparam logic [1:0] SerMul = 2'd1;
  localparam logic [1:0] SerDiv = 2'd2;

endpackage

FILE: hdl/um_alu_serial.sv
// Bit-serial arithmetic unit: add, multiply low word and unsigned divide,
// one bit per cycle. Uses um_alu_pkg.
module um_alu_serial (
  input  logic                         clk,
  input  logic                         rst_n,
  input  um_alu_pkg::ser_ctl_t         ctl,
  input  logic [um_alu_pkg::WordW-1:0] op_b,
  input  logic [um_alu_pkg::WordW-1:0] op_c,
  output logic                         done,
  output logic [um_alu_pkg::WordW-1:0] result
);

  localparam int unsigned W = um_alu_pkg::WordW;

  logic             busy_r, busy_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [W-1:0]     a_r, a_nxt;     // b shifter / dividend / multiplicand
  logic [W-1:0]     m_r, m_nxt;     // c shifter / multiplier / divisor
  logic [W-1:0]     acc_r, acc_nxt; // sum / product / remainder
  logic             cy_r, cy_nxt;
  logic [W:0]       rem_try;
  logic             sbit;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sel_nxt  = sel_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cy_nxt   = cy_r;
    rem_try  = {acc_r[W-1:0], a_r[W-1]} - {1'b0, m_r};
    sbit     = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      sel_nxt  = ctl.sel;
      a_nxt    = op_b;
      m_nxt    = op_c;
      acc_nxt  = '0;
      cy_nxt   = 1'b0;
    end else if (busy_r) begin
      case (sel_r)
        um_alu_pkg::SerAdd: begin
          // LSB first; sum bits enter acc at the top
          sbit    = a_r[0] ^ m_r[0] ^ cy_r;
          cy_nxt  = (a_r[0] & m_r[0]) | (cy_r & (a_r[0] ^ m_r[0]));
          a_nxt   = a_r >> 1;
          m_nxt   = m_r >> 1;
          acc_nxt = {sbit, acc_r[W-1:1]};
        end
        um_alu_pkg::SerMul: begin
          // shift-add, multiplier LSB first, multiplicand moves left
          if (m_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = a_r << 1;
          m_nxt = m_r >> 1;
        end
        default: begin
          // restoring division, quotient collects in a_r
          if (!rem_try[W]) begin
            acc_nxt = rem_try[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[W-2:0], a_r[W-1]};
            a_nxt   = {a_r[W-2:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      sel_r  <= um_alu_pkg::SerAdd;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      sel_r  <= sel_nxt;
    end
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    cy_r  <= cy_nxt;
  end

  assign done   = busy_r && cnt_r == 6'(W - 1);
  assign result = (sel_r == um_alu_pkg::SerDiv) ? a_nxt : acc_nxt;

endmodule

FILE: hdl/um_register_alu_execute_top.sv
// Top level of the UM32 register ALU execute block.
// Uses um_alu_pkg and um_alu_serial.
//
// Executes one UM32 instruction per request against REGISTER_COUNT 32-bit
// registers, all zero after reset. Add, multiply and divide run in a
// bit-serial unit (states EXEC, SER, OUT); cmov, nand, load immediate,
// input, output and a divide by zero go from EXEC to OUT. One request is
// in work at a time; a new request is taken once the previous result has
// left the output register. Register indexes wrap modulo REGISTER_COUNT.
module um_register_alu_execute_top #(
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  um_alu_pkg::req_t    in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output um_alu_pkg::res_t    out_res
);

  localparam int unsigned IdxW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned W    = um_alu_pkg::WordW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SER  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  um_alu_pkg::req_t     req_r;
  logic [W-1:0]         regs_r [REGISTER_COUNT];
  logic [W-1:0]         vb, vc;
  logic [IdxW-1:0]      ia, ib, ic, dest;
  um_alu_pkg::res_t     res_r, res_nxt;
  um_alu_pkg::ser_ctl_t ser_ctl;
  logic                 ser_done;
  logic [W-1:0]         ser_res;
  logic                 wr_en;
  logic [W-1:0]         wr_val;
  um_alu_pkg::op_t      op;

  // 3-bit field to register index: small constant lookup table
  function automatic logic [IdxW-1:0] wrap(input logic [2:0] f);
    logic [3:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (f == 3'(k)) m = 4'(k % REGISTER_COUNT);
    end
    return m[IdxW-1:0];
  endfunction

  assign op = um_alu_pkg::op_t'(req_r.operation);
  assign ia = wrap(req_r.reg_a);
  assign ib = wrap(req_r.reg_b);
  assign ic = wrap(req_r.reg_c);
  assign vb = regs_r[ib];
  assign vc = regs_r[ic];

  um_alu_serial u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ser_ctl),
    .op_b   (vb),
    .op_c   (vc),
    .done   (ser_done),
    .result (ser_res)
  );

  always_comb begin
    state_nxt   = state_r;
    ser_ctl     = '0;
    wr_en       = 1'b0;
    wr_val      = '0;
    dest        = ia;
    res_nxt     = res_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        res_nxt = '0;
        case (op)
          um_alu_pkg::OP_CMOV: if (vc != '0) begin wr_en = 1'b1; wr_val = vb; end
          um_alu_pkg::OP_NAND: begin wr_en = 1'b1; wr_val = ~(vb & vc); end
          um_alu_pkg::OP_IMM:  begin wr_en = 1'b1; wr_val = req_r.immediate; end
          um_alu_pkg::OP_IN: begin
            wr_en  = 1'b1;
            dest   = ic;
            wr_val = req_r.in_end ? '1 : W'(req_r.in_byte);
          end
          um_alu_pkg::OP_OUT: begin
            if (vc > W'(255)) res_nxt.fault = um_alu_pkg::FAULT_OUT_RANGE;
            else begin
              res_nxt.out_byte       = vc[7:0];
              res_nxt.out_byte_valid = 1'b1;
            end
          end
          um_alu_pkg::OP_DIV: begin
            if (vc == '0) res_nxt.fault = um_alu_pkg::FAULT_DIV_ZERO;
            else begin
              ser_ctl.start = 1'b1;
              ser_ctl.sel   = um_alu_pkg::SerDiv;
            end
          end
          default: begin
            ser_ctl.start = 1'b1;
            ser_ctl.sel   = (op == um_alu_pkg::OP_ADD) ? um_alu_pkg::SerAdd
                                                       : um_alu_pkg::SerMul;
          end
        endcase
        res_nxt.written_value = wr_val;
        state_nxt = ser_ctl.start ? S_SER : S_OUT;
      end
      S_SER: if (ser_done) begin
        wr_en   = 1'b1;
        wr_val  = ser_res;
        res_nxt.written_value = ser_res;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < REGISTER_COUNT; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) regs_r[dest] <= wr_val;
    end
    if (state_r == S_IDLE && in_valid) req_r <= in_req;
    res_r <= res_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_res   = res_r;

endmodule

FILE: hdl/um_alu_checker.sv
// Port-level checker for um_register_alu_execute_top, bound to the top.
// Uses um_alu_pkg.
module um_alu_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input um_alu_pkg::res_t out_res,
  input logic             out_valid,
  input logic             out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.fault != um_alu_pkg::FAULT_NONE |->
      !out_res.out_byte_valid && out_res.written_value == '0)
    else $error("fault result carries data");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

endmodule

bind um_register_alu_execute_top um_alu_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_res   (out_res),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
